@@ hdl/qjt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qjt_pkg
// shared types and codes for the quintic joint trajectory generator
// ----------------------------------------------------------------------------
package qjt_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_TICK   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_SETPOINT = 2'd0,
        ST_IDLE     = 2'd1,
        ST_CANCELED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_T2,
        S_T3,
        S_INNER,
        S_S,
        S_JSUB,
        S_JMUL,
        S_JADD,
        S_OUT,
        S_REPLY
    } state_t;

endpackage
`default_nettype wire

@@ hdl/qjt_serial_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qjt_serial_mul
// shift-add signed by unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module qjt_serial_mul #(
    parameter int AW = 34,
    parameter int BW = 26
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [AW-1:0] a,
    input  wire logic        [BW-1:0] b,
    output logic signed [AW+BW-1:0]   p,
    output logic                      done
);
    localparam int CW = $clog2(BW + 1);

    logic signed [AW+BW-1:0] acc_reg, acc_next;
    logic signed [AW+BW-1:0] mc_reg, mc_next;
    logic [BW-1:0] mr_reg, mr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mr_reg  <= mr_next;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mr_next   = mr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = (AW+BW)'(a);
            mr_next   = b;
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mr_reg[0])
                acc_next = acc_reg + mc_reg;
            mc_next  = mc_reg <<< 1;
            mr_next  = mr_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign p    = acc_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

@@ hdl/qjt_serial_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qjt_serial_div
// restoring divider for tau = (i << F) / n, one quotient bit per cycle
// ----------------------------------------------------------------------------
module qjt_serial_div #(
    parameter int NW = 40,
    parameter int DW = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [NW-1:0] quo,
    output logic               done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

@@ hdl/quintic_joint_trajectory.sv @@
`timescale 1ns / 1ps
`default_nettype none
// sequence: a tick runs S_DIV, S_T2, S_T3, S_INNER and S_S, then S_JSUB, S_JMUL and S_JADD
//   for each joint, one setpoint per joint, then S_OUT; it holds the input until back in S_IDLE
// idle and cancel replies pass through S_REPLY into the output register; a load writes the stores
// throughput: one request at a time; a stalled output register holds the sequence in place
// reset: stores cleared, block idle, step_count = 100
// ----------------------------------------------------------------------------
// quintic_joint_trajectory
// quintic blend trajectory sequencer over a bit-serial divider and multiplier
// ----------------------------------------------------------------------------
module quintic_joint_trajectory #(
    parameter int JOINTS        = 7,
    parameter int TAU_FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         opcode,
    input  wire logic [3:0]         joint_index,
    input  wire logic signed [31:0] start_pos,
    input  wire logic signed [31:0] goal_pos,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [3:0]              joint_number,
    output logic signed [31:0]      position,
    output logic                    last,
    output logic [1:0]              status,
    output logic                    final_step
);
    localparam int F   = TAU_FRAC_BITS;
    localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int TW  = F + 1;           // tau in [0, 2^F]
    localparam int NW  = 16 + F;          // dividend width
    localparam int AW  = F + 6;           // signed operand holds inner up to 10*2^F
    localparam int MA  = (AW > 34) ? AW : 34;
    localparam int MB  = TW;
    localparam int PW  = MA + MB;

    logic signed [31:0] start_mem [JOINTS];
    logic signed [31:0] goal_mem  [JOINTS];

    qjt_pkg::state_t state_reg, state_next;
    logic [15:0] step_count_reg;
    logic [15:0] step_reg, step_next;
    logic        moving_reg, moving_next;
    logic [15:0] i_reg, i_next;
    logic        fin_reg, fin_next;
    logic [TW-1:0] tau_reg, tau_next, t2_reg, t2_next, t3_reg, t3_next, s_reg, s_next;
    logic [JW-1:0] j_reg, j_next;
    logic signed [MA-1:0] ma_reg, ma_next;
    logic [MB-1:0] mb_reg, mb_next;
    logic signed [32:0] a_reg, a_next;
    logic signed [34:0] res_reg, res_next;

    logic        ov_reg, ov_next;
    logic [3:0]  oj_reg, oj_next;
    logic [31:0] op_reg, op_next;
    logic        ol_reg, ol_next, of_reg, of_next;
    logic [1:0]  os_reg, os_next;

    // multiplier launch is registered so it sees the operands just loaded
    logic mul_start_reg, mul_start_next;
    logic mul_done;
    logic signed [PW-1:0] mul_p;
    logic div_start, div_done;
    logic [NW-1:0] div_q;
    logic [15:0] n_eff;
    // divider already launched for this tick
    logic seen_reg;

    logic signed [PW-1:0] shifted;
    logic [PW-1:0] ushift;
    logic signed [AW-1:0] inner;
    logic accept, out_free;

    assign n_eff   = (step_count_reg == 16'd0) ? 16'd1 : step_count_reg;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != qjt_pkg::S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    qjt_serial_div #(.NW(NW), .DW(16)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num({i_reg, {F{1'b0}}}), .den(n_eff), .quo(div_q), .done(div_done)
    );

    qjt_serial_mul #(.AW(MA), .BW(MB)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start_reg), .a(ma_reg), .b(mb_reg),
        .p(mul_p), .done(mul_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qjt_pkg::S_IDLE;
            step_count_reg <= 16'd100;
            step_reg       <= '0;
            moving_reg     <= 1'b0;
            ov_reg         <= 1'b0;
            mul_start_reg  <= 1'b0;
            for (int k = 0; k < JOINTS; k++)
            begin
                start_mem[k] <= '0;
                goal_mem[k]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            moving_reg    <= moving_next;
            ov_reg        <= ov_next;
            mul_start_reg <= mul_start_next;
            if (cfg_we)
                step_count_reg <= cfg_data;
            if (accept && opcode == qjt_pkg::OP_LOAD && {28'd0, joint_index} < JOINTS)
            begin
                start_mem[joint_index[JW-1:0]] <= start_pos;
                goal_mem[joint_index[JW-1:0]]  <= goal_pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        fin_reg <= fin_next;
        tau_reg <= tau_next;
        t2_reg  <= t2_next;
        t3_reg  <= t3_next;
        s_reg   <= s_next;
        j_reg   <= j_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        a_reg   <= a_next;
        res_reg <= res_next;
        oj_reg  <= oj_next;
        op_reg  <= op_next;
        ol_reg  <= ol_next;
        of_reg  <= of_next;
        os_reg  <= os_next;
    end

    assign shifted = mul_p >>> F;   // arithmetic shift floors toward minus infinity
    assign ushift  = mul_p >> F;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        moving_next = moving_reg;
        i_next = i_reg;  fin_next = fin_reg;
        tau_next = tau_reg; t2_next = t2_reg; t3_next = t3_reg; s_next = s_reg;
        j_next = j_reg; ma_next = ma_reg; mb_next = mb_reg;
        a_next = a_reg; res_next = res_reg;
        ov_next = ov_reg && out_stall;
        oj_next = oj_reg; op_next = op_reg; ol_next = ol_reg;
        of_next = of_reg; os_next = os_reg;
        div_start = 1'b0;
        mul_start_next = 1'b0;
        inner = '0;
        case (state_reg)
            qjt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        qjt_pkg::OP_LOAD:
                        begin
                            if ({28'd0, joint_index} < JOINTS)
                            begin
                                step_next   = '0;
                                moving_next = 1'b1;
                            end
                        end
                        qjt_pkg::OP_TICK:
                        begin
                            if (!moving_reg)
                            begin
                                os_next = qjt_pkg::ST_IDLE;
                                state_next = qjt_pkg::S_REPLY;
                            end
                            else
                            begin
                                if ({1'b0, step_reg} + 17'd1 >= {1'b0, n_eff})
                                begin
                                    i_next = n_eff;
                                    fin_next = 1'b1;
                                end
                                else
                                begin
                                    i_next = step_reg + 16'd1;
                                    fin_next = 1'b0;
                                end
                                state_next = qjt_pkg::S_DIV;
                            end
                        end
                        qjt_pkg::OP_CANCEL:
                        begin
                            os_next = moving_reg ? qjt_pkg::ST_CANCELED : qjt_pkg::ST_IDLE;
                            moving_next = 1'b0;
                            step_next = '0;
                            state_next = qjt_pkg::S_REPLY;
                        end
                        default: ;
                    endcase
                end
            end
            qjt_pkg::S_REPLY:
            begin
                ov_next = 1'b1;
                oj_next = '0; op_next = '0; ol_next = 1'b1; of_next = 1'b0;
                state_next = qjt_pkg::S_IDLE;
            end
            qjt_pkg::S_DIV:
            begin
                // i_reg is loaded, start once then wait
                if (!seen_reg)
                    div_start = 1'b1;
                else if (div_done)
                begin
                    tau_next = div_q[TW-1:0];
                    ma_next  = MA'(div_q[TW-1:0]);
                    mb_next  = div_q[TW-1:0];
                    mul_start_next = 1'b1;
                    state_next = qjt_pkg::S_T2;
                end
            end
            qjt_pkg::S_T2:
            begin
                if (mul_done)
                begin
                    t2_next = ushift[TW-1:0];
                    ma_next = MA'(ushift[TW-1:0]);
                    mb_next = tau_reg;
                    mul_start_next = 1'b1;
                    state_next = qjt_pkg::S_T3;
                end
            end
            qjt_pkg::S_T3:
            begin
                if (mul_done)
                begin
                    t3_next = ushift[TW-1:0];
                    state_next = qjt_pkg::S_INNER;
                end
            end
            qjt_pkg::S_INNER:
            begin
                inner = AW'(10) * (AW'(1) << F) - AW'(15) * AW'(tau_reg)
                        + AW'(6) * AW'(t2_reg);
                if (inner < 0)
                    inner = '0;
                ma_next = MA'(inner);
                mb_next = t3_reg;
                mul_start_next = 1'b1;
                state_next = qjt_pkg::S_S;
            end
            qjt_pkg::S_S:
            begin
                if (mul_done)
                begin
                    if (ushift > PW'(1 << F))
                        s_next = TW'(1 << F);
                    else
                        s_next = ushift[TW-1:0];
                    j_next = '0;
                    state_next = qjt_pkg::S_JSUB;
                end
            end
            qjt_pkg::S_JSUB:
            begin
                a_next  = 33'(start_mem[j_reg]);
                ma_next = MA'(33'(goal_mem[j_reg]) - 33'(start_mem[j_reg]));
                mb_next = s_reg;
                mul_start_next = 1'b1;
                state_next = qjt_pkg::S_JMUL;
            end
            qjt_pkg::S_JMUL:
            begin
                if (mul_done)
                begin
                    res_next = 35'(a_reg) + 35'(shifted);
                    state_next = qjt_pkg::S_JADD;
                end
            end
            qjt_pkg::S_JADD:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    oj_next = 4'(j_reg);
                    if (res_reg > 35'sh07FFFFFFF)
                        op_next = 32'h7FFFFFFF;
                    else if (res_reg < -35'sh080000000)
                        op_next = 32'h80000000;
                    else
                        op_next = res_reg[31:0];
                    ol_next = (32'(j_reg) == JOINTS - 1);
                    os_next = qjt_pkg::ST_SETPOINT;
                    of_next = fin_reg;
                    if (32'(j_reg) == JOINTS - 1)
                    begin
                        state_next = qjt_pkg::S_OUT;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = qjt_pkg::S_JSUB;
                    end
                end
            end
            qjt_pkg::S_OUT:
            begin
                if (fin_reg)
                begin
                    moving_next = 1'b0;
                    step_next = '0;
                end
                else
                    step_next = i_reg;
                state_next = qjt_pkg::S_IDLE;
            end
            default: state_next = qjt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (state_reg != qjt_pkg::S_DIV)
            seen_reg <= 1'b0;
        else
            seen_reg <= 1'b1;
    end

    assign out_valid    = ov_reg;
    assign joint_number = oj_reg;
    assign position     = op_reg;
    assign last         = ol_reg;
    assign status       = os_reg;
    assign final_step   = of_reg;
endmodule
`default_nettype wire

@@ verif/tb_quintic_joint_trajectory.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quintic_joint_trajectory
// drives load, tick and cancel requests through the trajectory generator and
// compares every setpoint and status result with a software quintic blend
// ----------------------------------------------------------------------------
module tb_quintic_joint_trajectory;

    localparam int JOINTS = 7;
    localparam int FRAC = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [3:0]  joint;
        logic [31:0] pos;
        logic        lst;
        logic [1:0]  stat;
        logic        fin;
    } setpoint_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] opcode = qjt_pkg::OP_NONE;
    logic [3:0] joint_index = '0;
    logic signed [31:0] start_pos = '0;
    logic signed [31:0] goal_pos = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] joint_number;
    logic signed [31:0] position;
    logic last;
    logic [1:0] status;
    logic final_step;

    // predictor state
    longint start_mem [JOINTS];
    longint goal_mem [JOINTS];
    int unsigned step_now;
    bit in_motion;
    int unsigned ticks_per_move;

    setpoint_t expected_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    longint cycles = 0;

    quintic_joint_trajectory i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .joint_index(joint_index), .start_pos(start_pos), .goal_pos(goal_pos),
        .out_valid(out_valid), .out_stall(out_stall),
        .joint_number(joint_number), .position(position), .last(last),
        .status(status), .final_step(final_step)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quintic_joint_trajectory: mismatch");
            $finish;
        end
    end

    // receiver stall, with a long hold-off stretch on demand
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic longint blend_of(longint unsigned tau);
        longint unsigned t2, t3;
        longint inner, s;
        t2 = (tau * tau) >> FRAC;
        t3 = (t2 * tau) >> FRAC;
        inner = 10 * (64'sd1 << FRAC) - 15 * longint'(tau) + 6 * longint'(t2);
        if (inner < 0)
            inner = 0;
        s = longint'((t3 * longint'(inner)) >> FRAC);
        if (s > (64'sd1 << FRAC))
            s = 64'sd1 << FRAC;
        return s;
    endfunction

    function automatic logic [31:0] blend_position(longint a, longint b, longint s);
        longint prod, q, res;
        prod = (b - a) * s;
        q = prod >>> FRAC;  // arithmetic shift floors toward minus infinity
        res = a + q;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[31:0];
    endfunction

    function automatic setpoint_t status_only(logic [1:0] st);
        setpoint_t r;
        r.joint = '0; r.pos = '0; r.lst = 1'b1; r.stat = st; r.fin = 1'b0;
        return r;
    endfunction

    task automatic predict_request(logic [1:0] op, logic [3:0] idx,
                                   logic [31:0] sp, logic [31:0] gp);
        int unsigned n, i;
        longint unsigned tau;
        longint s;
        bit fin;
        setpoint_t r;
        if (op == qjt_pkg::OP_LOAD)
        begin
            if (idx < JOINTS)
            begin
                start_mem[idx] = longint'(signed'(sp));
                goal_mem[idx] = longint'(signed'(gp));
                step_now = 0;
                in_motion = 1'b1;
            end
        end
        else if (op == qjt_pkg::OP_TICK)
        begin
            if (!in_motion)
                expected_q.push_back(status_only(qjt_pkg::ST_IDLE));
            else
            begin
                n = (ticks_per_move == 0) ? 1 : ticks_per_move;
                i = step_now + 1;
                if (i > n)
                    i = n;
                fin = (i == n);
                tau = (longint'(i) << FRAC) / n;
                s = blend_of(tau);
                for (int j = 0; j < JOINTS; j++)
                begin
                    r.joint = j[3:0];
                    r.pos = blend_position(start_mem[j], goal_mem[j], s);
                    r.lst = (j == JOINTS - 1);
                    r.stat = qjt_pkg::ST_SETPOINT;
                    r.fin = fin;
                    expected_q.push_back(r);
                end
                if (fin)
                begin
                    in_motion = 1'b0;
                    step_now = 0;
                end
                else
                    step_now = i;
            end
        end
        else if (op == qjt_pkg::OP_CANCEL)
        begin
            expected_q.push_back(status_only(in_motion ? qjt_pkg::ST_CANCELED
                                                       : qjt_pkg::ST_IDLE));
            in_motion = 1'b0;
            step_now = 0;
        end
    endtask

    // checker
    always @(posedge clk)
    begin
        setpoint_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result joint %0d pos %h", joint_number, position);
            end
            else
            begin
                e = expected_q.pop_front();
                if (joint_number !== e.joint || position !== e.pos || last !== e.lst
                    || status !== e.stat || final_step !== e.fin)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"result mismatch: exp j%0d %h l%0d s%0d f%0d",
                                  " got j%0d %h l%0d s%0d f%0d"},
                                 e.joint, e.pos, e.lst, e.stat, e.fin, joint_number,
                                 position, last, status, final_step);
                end
            end
        end
    end

    // leaves valid high; an idle gap before the next request or drain() takes it down
    task automatic send_request(logic [1:0] op, logic [3:0] idx,
                                logic [31:0] sp, logic [31:0] gp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        joint_index <= idx;
        start_pos <= sp;
        goal_pos <= gp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(op, idx, sp, gp);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        // a trailing load or ignored request may still be in flight
        repeat (2500) @(posedge clk);
    endtask

    task automatic write_step_count(logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        ticks_per_move = v;
    endtask

    task automatic load_all_joints();
        for (int j = 0; j < JOINTS; j++)
            send_request(qjt_pkg::OP_LOAD, j[3:0], $urandom, $urandom);
    endtask

    task automatic test_directed();
        // idle tick and idle cancel
        send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);
        send_request(qjt_pkg::OP_CANCEL, 4'd0, '0, '0);
        write_step_count(16'd3);
        // field extremes, including saturating spans
        send_request(qjt_pkg::OP_LOAD, 4'd0, 32'h8000_0000, 32'h7fff_ffff);
        send_request(qjt_pkg::OP_LOAD, 4'd1, 32'h7fff_ffff, 32'h8000_0000);
        send_request(qjt_pkg::OP_LOAD, 4'd6, 32'hffff_ffff, 32'h0000_0001);
        // out of range joint
        send_request(qjt_pkg::OP_LOAD, 4'd15, 32'h1234_5678, 32'h8765_4321);
        send_request(qjt_pkg::OP_LOAD, 4'd7, 32'hffff_ffff, 32'hffff_ffff);
        send_request(qjt_pkg::OP_NONE, 4'd3, 32'h5555_5555, 32'haaaa_aaaa);
        repeat (3) send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);
        send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);  // idle after the final step
        // cancel during a motion
        send_request(qjt_pkg::OP_LOAD, 4'd2, 32'h0001_0000, 32'hfffe_0000);
        send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);
        send_request(qjt_pkg::OP_CANCEL, 4'd0, '0, '0);
        // step count of zero behaves as one
        write_step_count(16'd0);
        send_request(qjt_pkg::OP_LOAD, 4'd3, 32'h0000_8000, 32'h0003_0000);
        send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);
        // step count lowered below the current step mid motion
        write_step_count(16'd10);
        send_request(qjt_pkg::OP_LOAD, 4'd4, 32'h0000_0000, 32'h0010_0000);
        repeat (5) send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);
        write_step_count(16'd2);
        send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);
        write_step_count(16'hffff);
        send_request(qjt_pkg::OP_LOAD, 4'd5, 32'h0000_0000, 32'h7fff_ffff);
        repeat (2) send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);
        write_step_count(16'd1);
        send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);
    endtask

    task automatic test_random(int count);
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                load_all_joints();
            else if (r < 16)
                send_request(qjt_pkg::OP_LOAD, 4'($urandom_range(15)), $urandom, $urandom);
            else if (r < 85)
                send_request(qjt_pkg::OP_TICK, 4'($urandom), $urandom, $urandom);
            else if (r < 95)
                send_request(qjt_pkg::OP_CANCEL, 4'($urandom), $urandom, $urandom);
            else
                send_request(qjt_pkg::OP_NONE, 4'($urandom), $urandom, $urandom);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        load_all_joints();
        repeat (8) send_request(qjt_pkg::OP_TICK, 4'd0, '0, '0);
    endtask

    initial
    begin
        for (int j = 0; j < JOINTS; j++)
        begin
            start_mem[j] = 0;
            goal_mem[j] = 0;
        end
        step_now = 0;
        in_motion = 1'b0;
        ticks_per_move = 100;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_step_count(16'd8);
        send_idle_pct = 38;
        recv_stall_pct = 58;
        test_random(30);
        write_step_count(16'd5);
        send_idle_pct = 58;
        recv_stall_pct = 38;
        test_random(30);
        write_step_count(16'd12);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(30);
        test_backpressure();
        drain();

        if (errors == 0 && expected_q.size() == 0)
            $display("quintic_joint_trajectory: match");
        else
            $display("quintic_joint_trajectory: mismatch");
        $finish;
    end

endmodule
